// ----- rtl/ising_metropolis_spin_flip_assert.svh -----
// assertion macros for the spin-flip engine
`ifndef ISING_METROPOLIS_SPIN_FLIP_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_FLIP_ASSERT_SVH

// same-cycle implication
`define IMSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/imsf_pkg.sv -----
// shared constants, codes and index helpers for the spin-flip engine
package imsf_pkg;

  localparam int SIDE   = 32;
  localparam int IDX_W  = $clog2(SIDE);
  localparam int SITES  = SIDE * SIDE;
  localparam int SUM_W  = 12;
  localparam int LIM_W  = 17;
  localparam int DRAW_W = 16;
  localparam int CFG_W  = 1;

  localparam logic MODE_FLIP = 1'b0;
  localparam logic MODE_FILL = 1'b1;

  localparam logic [CFG_W-1:0] CFG_LIMIT_SMALL = 1'b0;
  localparam logic [CFG_W-1:0] CFG_LIMIT_LARGE = 1'b1;

  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(SITES);

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(SIDE - 1)) res = '0;
    else res = idx + IDX_W'(1);
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) res = IDX_W'(SIDE - 1);
    else res = idx - IDX_W'(1);
    return res;
  endfunction

endpackage

// ----- rtl/imsf_ram.sv -----
// generic single-write ram with registered read
module imsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ising_metropolis_spin_flip.sv -----
// metropolis spin-flip engine for a periodic 2d ising lattice
// an accepted item passes the stage register, then the result register
// throughput: one item per cycle unless result_ready stalls; each row memory: one read, one write per cycle
// a row written on one edge reaches the next item through a forwarding register
// reset: synchronous; all rows read as +1 through cleared row valid bits, sum 1024, limits 0
// no clearing pass: the block accepts items in the first cycle after reset
module ising_metropolis_spin_flip (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [imsf_pkg::CFG_W-1:0]      cfg_index,
  input  logic [imsf_pkg::LIM_W-1:0]      cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            mode,
  input  logic [imsf_pkg::IDX_W-1:0]      row,
  input  logic [imsf_pkg::IDX_W-1:0]      col,
  input  logic [imsf_pkg::DRAW_W-1:0]     uniform_draw,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            flipped,
  output logic                            site_spin,
  output logic signed [imsf_pkg::SUM_W-1:0] magnetization
);

  import imsf_pkg::*;

  logic [LIM_W-1:0] limit_small;
  logic [LIM_W-1:0] limit_large;

  logic              p_valid;
  logic              p_mode;
  logic [IDX_W-1:0]  p_row;
  logic [IDX_W-1:0]  p_col;
  logic [DRAW_W-1:0] p_draw;
  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_row;
  logic [SIDE-1:0]   fwd_data;

  logic [SIDE-1:0]   row_valid;
  logic [SUM_W-1:0]  spin_sum;
  logic [SUM_W-1:0]  spin_sum_next;

  logic              accept;
  logic              move;
  logic              wr_en;
  logic [SIDE-1:0]   wr_data;

  logic [IDX_W-1:0]  row_up;
  logic [IDX_W-1:0]  row_dn;
  logic [SIDE-1:0]   ram_up;
  logic [SIDE-1:0]   ram_cur;
  logic [SIDE-1:0]   ram_dn;
  logic [SIDE-1:0]   bits_up;
  logic [SIDE-1:0]   bits_cur;
  logic [SIDE-1:0]   bits_dn;

  logic              s;
  logic [3:0]        aligned;
  logic [2:0]        k;
  logic              do_flip;

  assign move       = p_valid & (~result_valid | result_ready);
  assign item_ready = ~p_valid | move;
  assign accept     = item_valid & item_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_small <= '0;
      limit_large <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT_SMALL: limit_small <= cfg_data;
        CFG_LIMIT_LARGE: limit_large <= cfg_data;
        default: ;
      endcase
    end
  end

  // row memories, one per read port, written together
  imsf_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_up (
    .clk(clk), .we(wr_en), .waddr(p_row), .wdata(wr_data),
    .re(accept), .raddr(wrap_up(row)), .rdata(ram_up)
  );

  imsf_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_cur (
    .clk(clk), .we(wr_en), .waddr(p_row), .wdata(wr_data),
    .re(accept), .raddr(row), .rdata(ram_cur)
  );

  imsf_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_dn (
    .clk(clk), .we(wr_en), .waddr(p_row), .wdata(wr_data),
    .re(accept), .raddr(wrap_down(row)), .rdata(ram_dn)
  );

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (accept) begin
        p_valid   <= 1'b1;
        fwd_valid <= wr_en;
      end else if (move) begin
        p_valid   <= 1'b0;
      end
    end
    if (accept) begin
      p_mode   <= mode;
      p_row    <= row;
      p_col    <= col;
      p_draw   <= uniform_draw;
      fwd_row  <= p_row;
      fwd_data <= wr_data;
    end
  end

  assign row_up = wrap_up(p_row);
  assign row_dn = wrap_down(p_row);

  // forwarded write, else stored row, else untouched row of +1
  always_comb begin
    if (fwd_valid && fwd_row == row_up) bits_up = fwd_data;
    else if (row_valid[row_up]) bits_up = ram_up;
    else bits_up = '1;
    if (fwd_valid && fwd_row == p_row) bits_cur = fwd_data;
    else if (row_valid[p_row]) bits_cur = ram_cur;
    else bits_cur = '1;
    if (fwd_valid && fwd_row == row_dn) bits_dn = fwd_data;
    else if (row_valid[row_dn]) bits_dn = ram_dn;
    else bits_dn = '1;
  end

  assign s = bits_cur[p_col];
  assign aligned[0] = ~(bits_up[p_col] ^ s);
  assign aligned[1] = ~(bits_dn[p_col] ^ s);
  assign aligned[2] = ~(bits_cur[wrap_up(p_col)] ^ s);
  assign aligned[3] = ~(bits_cur[wrap_down(p_col)] ^ s);
  assign k = 3'(aligned[0]) + 3'(aligned[1]) + 3'(aligned[2]) + 3'(aligned[3]);

  // energy rise in units of 2J is 2k-4
  always_comb begin
    if (k <= 3'd2) do_flip = 1'b1;
    else if (k == 3'd3) do_flip = {1'b0, p_draw} < limit_small;
    else do_flip = {1'b0, p_draw} < limit_large;
  end

  assign wr_en   = move & (p_mode == MODE_FLIP) & do_flip;
  assign wr_data = bits_cur ^ (SIDE'(1) << p_col);

  always_comb begin
    if (p_mode == MODE_FILL) spin_sum_next = SUM_RESET;
    else if (!do_flip) spin_sum_next = spin_sum;
    else if (s) spin_sum_next = spin_sum - SUM_W'(2);
    else spin_sum_next = spin_sum + SUM_W'(2);
  end

  // lattice bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      spin_sum     <= SUM_RESET;
      result_valid <= 1'b0;
    end else begin
      if (move) begin
        spin_sum     <= spin_sum_next;
        result_valid <= 1'b1;
        if (p_mode == MODE_FILL) begin
          row_valid <= '0;
        end else if (wr_en) begin
          row_valid[p_row] <= 1'b1;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (move) begin
      flipped       <= (p_mode == MODE_FLIP) & do_flip;
      site_spin     <= (p_mode == MODE_FILL) ? 1'b1 : (s ^ do_flip);
      magnetization <= spin_sum_next;
    end
  end

`include "ising_metropolis_spin_flip_assert.svh"

  `IMSF_ASSERT_NEXT(a_fill_result, move && p_mode == MODE_FILL,
    !flipped && site_spin && row_valid == '0, "fill item left a stale lattice or result")
  `IMSF_ASSERT_NEXT(a_sum_idle, !move, spin_sum == $past(spin_sum),
    "magnetization changed with no item leaving the stage")
  `IMSF_ASSERT_NEXT(a_sum_reject, move && p_mode == MODE_FLIP && !do_flip,
    $stable(spin_sum) && !flipped, "rejected flip changed magnetization")
  `IMSF_ASSERT_NEXT(a_stage_hold, p_valid && !move,
    p_valid && $stable(p_row) && $stable(p_col), "stalled stage item lost")
  `IMSF_ASSERT_NOW(a_result_sum, result_valid, magnetization == spin_sum,
    "result magnetization differs from running sum")

endmodule
